[rtl/core/binary_arithmetic_encoder_top_defines.svh]
// ----------------------------------------------------------------------------
// Binary arithmetic encoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_ARITHMETIC_ENCODER_TOP_DEFINES_SVH
`define BINARY_ARITHMETIC_ENCODER_TOP_DEFINES_SVH

// same-cycle implication
`define BAE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BAE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bae_pkg.sv]
// ----------------------------------------------------------------------------
// Binary arithmetic encoder package
// Constants, command type and function codes shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bae_pkg;

  localparam int unsigned ProbBits = 12;
  localparam int unsigned ProbW    = ProbBits + 1;
  localparam int unsigned HbW      = 32 - ProbBits;
  localparam int unsigned LbPW     = ProbBits + ProbW;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [31:0] RangeLowReset  = 32'h0000_0000;
  localparam logic [31:0] RangeHighReset = 32'hFFFF_FFFF;
  localparam logic [31:0] ScaleVal       = 32'd1 << ProbBits;
  localparam logic [31:0] HalfVal        = ScaleVal >> 1;
  localparam logic [7:0]  FillByte       = 8'hFF;
  localparam logic [2:0]  MaxShift       = 3'd4;
  localparam logic [2:0]  LastSlot       = 3'd3;

  typedef enum logic {
    FUNC_ENCODE = 1'b0,
    FUNC_FINISH = 1'b1
  } bae_func_e;

  typedef struct packed {
    bae_func_e        func;
    logic             bit_value;
    logic [ProbW-1:0] prob;
  } bae_cmd_t;

endpackage

`default_nettype wire

[rtl/core/binary_arithmetic_encoder_top.sv]
// ----------------------------------------------------------------------------
// Binary arithmetic encoder top level
// 32-bit carry-less binary arithmetic encoder with byte output stream.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                         tuser / tlast
// s_axis    in   [0] bit_value, [13:1] prob_one  tuser[0] func
// m_axis    out  [7:0] out_byte                  tlast = last
//
// Encode item: product register, then split add, then each emitted byte,
//   as set by the range update loop in the back end.
// Finish item: a pop, then four bytes (top byte of low, then three fill bytes).
// A 4-entry command queue decouples input acceptance from the back end.
// Output stalls hold the back end; the input side stalls only on a full queue.
// Reset (rst_ni low, asynchronous) sets low to 0 and high to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_arithmetic_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [0] bit_value, [13:1] prob_one, [15:14] zero
  input  logic [0:0]  s_axis_tuser_i,   // [0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o
);
  import bae_pkg::*;

  logic     cmd_valid;
  logic     cmd_pop;
  bae_cmd_t cmd;

  bae_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .func_i      (bae_func_e'(s_axis_tuser_i[0])),
    .bit_value_i (s_axis_tdata_i[0]),
    .prob_one_i  (s_axis_tdata_i[13:1]),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  bae_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

[rtl/core/bae_front.sv]
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts items, saturates the probability and queues commands for the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "binary_arithmetic_encoder_top_defines.svh"

module bae_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bae_pkg::bae_func_e  func_i,
  input  logic                bit_value_i,
  input  logic [12:0]         prob_one_i,
  output logic                cmd_valid_o,
  output bae_pkg::bae_cmd_t   cmd_o,
  input  logic                cmd_pop_i
);
  import bae_pkg::*;

  bae_cmd_t         q_mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [31:0]      prob_ext;
  logic [ProbW-1:0] prob_sat;
  bae_cmd_t         cmd_in;
  logic             push;
  logic             pop;

  assign prob_ext = {19'd0, prob_one_i};
  assign prob_sat = (prob_ext > ScaleVal) ? ScaleVal[ProbW-1:0] : prob_ext[ProbW-1:0];

  assign cmd_in.func      = func_i;
  assign cmd_in.bit_value = bit_value_i;
  assign cmd_in.prob      = prob_sat;

  assign in_ready_o  = (cnt_q != QCntW'(QDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = QPtrW'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = QPtrW'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = QCntW'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = QCntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `BAE_ASSERT_IMP(a_q_bound, 1'b1, cnt_q <= QCntW'(QDepth), "queue count above depth")
  `BAE_ASSERT_NXT(a_q_inc, push && !pop, cnt_q == QCntW'($past(cnt_q) + 1'b1), "queue count did not grow")
  `BAE_ASSERT_NXT(a_q_dec, pop && !push, cnt_q == QCntW'($past(cnt_q) - 1'b1), "queue count did not shrink")

endmodule

`default_nettype wire

[rtl/core/bae_back.sv]
// ----------------------------------------------------------------------------
// Encoder back end
// Splits the range, renormalizes and emits bytes through an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "binary_arithmetic_encoder_top_defines.svh"

module bae_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  bae_pkg::bae_cmd_t  cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o
);
  import bae_pkg::*;

  typedef enum logic [2:0] {
    S_SHIFT = 3'b001,
    S_ADD   = 3'b010,
    S_FIN   = 3'b100
  } bae_state_e;

  bae_state_e         state_q, state_d;
  logic [31:0]        lo_q, lo_d;
  logic [31:0]        hi_q, hi_d;
  logic [31:0]        prod_hb_q, prod_hb_d;
  logic [LbPW-1:0]    prod_lb_q, prod_lb_d;
  logic               bit_q, bit_d;
  logic [2:0]         cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               out_last_q, out_last_d;

  logic [31:0]        size;
  logic [HbW-1:0]     hb;
  logic [ProbBits-1:0] lb;
  logic [HbW+ProbW-1:0] hb_prod;
  logic [LbPW-1:0]    lb_prod;
  logic [LbPW:0]      rnd_sum;
  logic [31:0]        split;
  logic               match;
  logic               more;
  logic               out_free;
  logic               emit;
  logic [7:0]         emit_byte;
  logic               emit_last;

  assign size    = hi_q - lo_q - 32'd1;
  assign hb      = size[31:ProbBits];
  assign lb      = size[ProbBits-1:0];
  assign hb_prod = hb * cmd_i.prob;
  assign lb_prod = lb * cmd_i.prob;
  assign rnd_sum = {1'b0, prod_lb_q} + (LbPW+1)'(HalfVal);
  assign split   = lo_q + prod_hb_q + 32'(rnd_sum[LbPW:ProbBits]);

  assign match    = (lo_q[31:24] == hi_q[31:24]);
  assign more     = match && (cnt_q < MaxShift);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    prod_hb_d = prod_hb_q;
    prod_lb_d = prod_lb_q;
    bit_d     = bit_q;
    cnt_d     = cnt_q;
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    emit_byte = lo_q[31:24];
    emit_last = 1'b0;
    unique case (state_q)
      S_SHIFT: begin
        if (more) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_last = (cnt_q == LastSlot) || (lo_q[23:16] != hi_q[23:16]);
            lo_d      = {lo_q[23:0], 8'h00};
            hi_d      = {hi_q[23:0], FillByte};
            cnt_d     = 3'(cnt_q + 1'b1);
          end
        end else if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cnt_d     = '0;
          if (cmd_i.func == FUNC_FINISH) begin
            state_d = S_FIN;
          end else begin
            prod_hb_d = hb_prod[31:0];
            prod_lb_d = lb_prod;
            bit_d     = cmd_i.bit_value;
            state_d   = S_ADD;
          end
        end
      end
      S_ADD: begin
        if (bit_q) begin
          hi_d = split;
        end else begin
          lo_d = split + 32'd1;
        end
        cnt_d   = '0;
        state_d = S_SHIFT;
      end
      S_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = (cnt_q == '0) ? lo_q[31:24] : FillByte;
          emit_last = (cnt_q == LastSlot);
          cnt_d     = 3'(cnt_q + 1'b1);
          if (cnt_q == LastSlot) begin
            lo_d    = RangeLowReset;
            hi_d    = RangeHighReset;
            cnt_d   = '0;
            state_d = S_SHIFT;
          end
        end
      end
      default: begin
        state_d = S_SHIFT;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      out_last_d  = emit_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_hb_q  <= prod_hb_d;
    prod_lb_q  <= prod_lb_d;
    bit_q      <= bit_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SHIFT;
      lo_q        <= RangeLowReset;
      hi_q        <= RangeHighReset;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  `BAE_ASSERT_NXT(a_enc_pop, cmd_pop_o && (cmd_i.func == FUNC_ENCODE), state_q == S_ADD, "encode pop did not start split")
  `BAE_ASSERT_IMP(a_shift_bound, state_q == S_SHIFT, cnt_q <= MaxShift, "too many bytes for one item")
  `BAE_ASSERT_NXT(a_fin_reset, (state_q == S_FIN) && emit && emit_last, (lo_q == RangeLowReset) && (hi_q == RangeHighReset), "range not reset after finish")

endmodule

`default_nettype wire
